// ===== design/tdlr_pkg.sv =====
// ============================================================================
// Tilt direction LED ring - shared package
// Widths, register indexes, the arctangent table and the pipeline word types.
// ============================================================================
package tdlr_pkg;

    // Ring geometry
    localparam int RING_LEDS  = 16;
    localparam int SECTOR_W   = $clog2(RING_LEDS);
    localparam int RING_CNT_W = $clog2(RING_LEDS + 1);
    localparam int MASK_W     = 16;

    // Field and register widths
    localparam int ANGLE_W    = 13;
    localparam int THR_W      = 12;
    localparam int SPREAD_W   = 5;
    localparam int CFG_DATA_W = THR_W;
    localparam int REG_IDX_W  = 1;

    // Sum of squares of two signed angles, and the squared threshold
    localparam int SQ_W       = 2 * ANGLE_W - 1;
    localparam int SUM_W      = 2 * ANGLE_W;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(80 * 80);
    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(80);
    localparam logic [SPREAD_W-1:0] SPREAD_RESET = SPREAD_W'(3);

    // Rotation datapath
    localparam int SCALE_W         = 16;
    localparam int VEC_W           = 32;
    localparam int PHI_W           = 16;
    localparam int CORDIC_STEPS    = 14;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam logic [PHI_W-1:0] PHI_HALF_TURN = 16'h8000;
    localparam logic [PHI_W-1:0] PHI_ZERO_VEC  = 16'hC000;

    // Sector and mask arithmetic
    localparam int PROD_W = PHI_W + RING_CNT_W + 1;
    localparam int DIST_W = (SECTOR_W + 1 > SPREAD_W + 1) ? SECTOR_W + 1 : SPREAD_W + 1;

    // Stream word widths
    localparam int S_TDATA_W = ((2 * ANGLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((MASK_W + 1 + 7) / 8) * 8;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_FLAT_THRESHOLD = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPREAD_COUNT   = 1'd1;

    typedef struct packed {
        logic signed [VEC_W-1:0] u;
        logic signed [VEC_W-1:0] w;
        logic [PHI_W-1:0]        z;
    } tdlr_vec_t;

    typedef struct packed {
        logic flat;
        logic zero;
    } tdlr_tag_t;

    // atan(2^-i) in binary angle units, 65536 to the turn.
    function automatic logic [PHI_W-1:0] atan_turn(input int i);
        logic [PHI_W-1:0] r;
        case (i)
            0:       r = 16'd8192;
            1:       r = 16'd4836;
            2:       r = 16'd2555;
            3:       r = 16'd1297;
            4:       r = 16'd651;
            5:       r = 16'd326;
            6:       r = 16'd163;
            7:       r = 16'd81;
            8:       r = 16'd41;
            9:       r = 16'd20;
            10:      r = 16'd10;
            11:      r = 16'd5;
            12:      r = 16'd3;
            13:      r = 16'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/tdlr_front.sv =====
// ============================================================================
// Tilt direction LED ring - front stage
// Pre-rotates the tilt vector into the right half-plane, scales it for the
// rotation pipeline and squares both angles for the flat test.
// ============================================================================
module tdlr_front import tdlr_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      valid_in,
    input  logic signed [ANGLE_W-1:0] roll,
    input  logic signed [ANGLE_W-1:0] pitch,
    output logic                      valid_out,
    output tdlr_vec_t                 vec_out,
    output logic                      zero_out,
    output logic [SQ_W-1:0]           sq_roll,
    output logic [SQ_W-1:0]           sq_pitch
);

    logic signed [ANGLE_W:0]     roll_x;
    logic signed [ANGLE_W:0]     pitch_x;
    logic signed [ANGLE_W:0]     u0;
    logic signed [ANGLE_W:0]     w0;
    logic signed [2*ANGLE_W-1:0] roll_prod;
    logic signed [2*ANGLE_W-1:0] pitch_prod;
    tdlr_vec_t                   vec_next;

    logic                        valid_reg;
    tdlr_vec_t                   vec_reg;
    logic                        zero_reg;
    logic [SQ_W-1:0]             sq_roll_reg;
    logic [SQ_W-1:0]             sq_pitch_reg;

    // The direction is measured from the pitch axis towards minus roll.
    always_comb begin
        roll_x     = {roll[ANGLE_W-1], roll};
        pitch_x    = {pitch[ANGLE_W-1], pitch};
        roll_prod  = roll * roll;
        pitch_prod = pitch * pitch;
        if (pitch[ANGLE_W-1]) begin
            u0         = -pitch_x;
            w0         = roll_x;
            vec_next.z = PHI_HALF_TURN;
        end else begin
            u0         = pitch_x;
            w0         = -roll_x;
            vec_next.z = '0;
        end
        vec_next.u = {{(VEC_W-ANGLE_W-1-SCALE_W){u0[ANGLE_W]}}, u0, {SCALE_W{1'b0}}};
        vec_next.w = {{(VEC_W-ANGLE_W-1-SCALE_W){w0[ANGLE_W]}}, w0, {SCALE_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg      <= vec_next;
            zero_reg     <= (roll == '0) && (pitch == '0);
            sq_roll_reg  <= roll_prod[SQ_W-1:0];
            sq_pitch_reg <= pitch_prod[SQ_W-1:0];
        end
    end

    assign valid_out = valid_reg;
    assign vec_out   = vec_reg;
    assign zero_out  = zero_reg;
    assign sq_roll   = sq_roll_reg;
    assign sq_pitch  = sq_pitch_reg;

    // A pre-rotated vector never points into the left half-plane.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !vec_reg.u[VEC_W-1])
        else $error("front: pre-rotated vector has negative x");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_in && en) |=> valid_reg)
        else $error("front: accepted word did not enter the pipeline");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_reg))
        else $error("front: valid changed during a stall");

endmodule

// ===== design/tdlr_cordic.sv =====
// ============================================================================
// Tilt direction LED ring - vectoring rotation pipeline
// Drives the vector onto the x axis, two micro-rotations per register stage,
// accumulating the binary angle. Flags travel alongside the vector.
// ============================================================================
module tdlr_cordic import tdlr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      valid_in,
    input  tdlr_vec_t vec_in,
    input  tdlr_tag_t tag_in,
    output logic      valid_out,
    output tdlr_vec_t vec_out,
    output tdlr_tag_t tag_out
);

    function automatic tdlr_vec_t cordic_iter(input tdlr_vec_t v, input int i);
        tdlr_vec_t               r;
        logic signed [VEC_W-1:0] su;
        logic signed [VEC_W-1:0] sw;
        su = v.u;
        sw = v.w;
        if (!sw[VEC_W-1]) begin
            r.u = su + (sw >>> i);
            r.w = sw - (su >>> i);
            r.z = v.z + atan_turn(i);
        end else begin
            r.u = su - (sw >>> i);
            r.w = sw + (su >>> i);
            r.z = v.z - atan_turn(i);
        end
        return r;
    endfunction

    logic      valid_reg [CORDIC_STAGES];
    tdlr_vec_t vec_reg   [CORDIC_STAGES];
    tdlr_tag_t tag_reg   [CORDIC_STAGES];

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
        logic      v_valid;
        tdlr_vec_t v_in;
        tdlr_tag_t t_in;
        tdlr_vec_t v_next;

        if (s == 0) begin : g_first
            assign v_valid = valid_in;
            assign v_in    = vec_in;
            assign t_in    = tag_in;
        end else begin : g_rest
            assign v_valid = valid_reg[s-1];
            assign v_in    = vec_reg[s-1];
            assign t_in    = tag_reg[s-1];
        end

        always_comb begin
            v_next = v_in;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                if (s * STEPS_PER_STAGE + k < CORDIC_STEPS) begin
                    v_next = cordic_iter(v_next, s * STEPS_PER_STAGE + k);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                vec_reg[s] <= v_next;
                tag_reg[s] <= t_in;
            end
        end
    end

    assign valid_out = valid_reg[CORDIC_STAGES-1];
    assign vec_out   = vec_reg[CORDIC_STAGES-1];
    assign tag_out   = tag_reg[CORDIC_STAGES-1];

    // Starting in the right half-plane, x only grows, so it stays non-negative.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_out |-> !vec_out.u[VEC_W-1])
        else $error("cordic: x went negative");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && valid_reg[0]) |=> valid_reg[1])
        else $error("cordic: word lost between stages");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(valid_out))
        else $error("cordic: output valid changed during a stall");

endmodule

// ===== design/tdlr_sector_mask.sv =====
// ============================================================================
// Tilt direction LED ring - sector and LED mask stages
// Rounds the angle to a ring sector, then lights the run of LEDs around it.
// The second stage is the output register of the block.
// ============================================================================
module tdlr_sector_mask import tdlr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                valid_in,
    input  logic [PHI_W-1:0]    z_in,
    input  tdlr_tag_t           tag_in,
    input  logic [SPREAD_W-1:0] spread_count,
    output logic                valid_out,
    output logic [MASK_W-1:0]   ring_mask,
    output logic                center_on
);

    logic [PHI_W-1:0]      phi;
    logic [PROD_W-1:0]     prod;
    logic [RING_CNT_W:0]   sec_raw;
    logic [SECTOR_W-1:0]   sector_next;

    logic                  sec_valid_reg;
    logic [SECTOR_W-1:0]   sector_reg;
    logic                  flat_reg;

    logic [SPREAD_W-2:0]   half_spread;
    logic [DIST_W-1:0]     run_last;
    logic [DIST_W-1:0]     start;
    logic [DIST_W-1:0]     span_pos;
    logic                  all_on;
    logic [MASK_W-1:0]     mask_next;

    logic                  out_valid_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic                  center_reg;

    // Round half up to the nearest sector; a full turn wraps to sector zero.
    always_comb begin
        phi         = tag_in.zero ? PHI_ZERO_VEC : z_in;
        prod        = PROD_W'(phi) * PROD_W'(RING_LEDS) + PROD_W'(PHI_HALF_TURN);
        sec_raw     = prod[PROD_W-1:PHI_W];
        sector_next = (sec_raw == (RING_CNT_W+1)'(RING_LEDS)) ? '0 : sec_raw[SECTOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_valid_reg <= 1'b0;
        end else if (en) begin
            sec_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sector_reg <= sector_next;
            flat_reg   <= tag_in.flat;
        end
    end

    // Each LED is lit when its distance past the run start is within 2k.
    always_comb begin
        half_spread = spread_count[SPREAD_W-1:1];
        run_last    = DIST_W'({half_spread, 1'b0});
        all_on      = (run_last + DIST_W'(1)) >= DIST_W'(RING_LEDS);
        if (DIST_W'(sector_reg) >= DIST_W'(half_spread)) begin
            start = DIST_W'(sector_reg) - DIST_W'(half_spread);
        end else begin
            start = DIST_W'(sector_reg) + DIST_W'(RING_LEDS) - DIST_W'(half_spread);
        end
        span_pos  = '0;
        mask_next = '0;
        for (int j = 0; j < MASK_W; j++) begin
            if (j < RING_LEDS) begin
                span_pos = DIST_W'(j) + DIST_W'(RING_LEDS) - start;
                if (span_pos >= DIST_W'(RING_LEDS)) begin
                    span_pos = span_pos - DIST_W'(RING_LEDS);
                end
                mask_next[j] = !flat_reg && (all_on || (span_pos <= run_last));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= sec_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mask_reg   <= mask_next;
            center_reg <= flat_reg;
        end
    end

    assign valid_out = out_valid_reg;
    assign ring_mask = mask_reg;
    assign center_on = center_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && sec_valid_reg) |=> out_valid_reg)
        else $error("sector_mask: word lost before the output register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && sec_valid_reg && !flat_reg && RING_LEDS <= MASK_W)
            |=> mask_reg[$past(sector_reg)])
        else $error("sector_mask: centre sector LED not lit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && sec_valid_reg && flat_reg) |=> (mask_reg == '0) && center_reg)
        else $error("sector_mask: flat word lit the ring");

endmodule

// ===== design/tilt_direction_led_ring_top.sv =====
// ============================================================================
// Tilt direction LED ring - top level
// An accepted input word passes through the front stage, 7 rotation stages of
// two micro-rotations each, the sector stage and the output register to m_tvalid.
// Throughput: one word per cycle; a word waiting at the output with m_tready
// low freezes the whole pipeline.
// Reset (synchronous, aresetn low) clears all valid bits and loads the
// register defaults: flat threshold 80, spread count 3.
// ============================================================================
module tilt_direction_led_ring_top import tdlr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [REG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [12:0] roll_angle, [25:13] pitch_angle
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [15:0] ring_mask, [16] center_on
);

    logic [THR_W-1:0]    flat_threshold_reg;
    logic [SPREAD_W-1:0] spread_count_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;

    logic                en;
    logic                front_valid;
    tdlr_vec_t           front_vec;
    logic                front_zero;
    logic [SQ_W-1:0]     sq_roll;
    logic [SQ_W-1:0]     sq_pitch;
    logic [SUM_W-1:0]    mag_sq;
    tdlr_tag_t           front_tag;

    logic                rot_valid;
    tdlr_vec_t           rot_vec;
    tdlr_tag_t           rot_tag;

    logic                out_valid;
    logic [MASK_W-1:0]   ring_mask;
    logic                center_on;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flat_threshold_reg <= THR_RESET;
            spread_count_reg   <= SPREAD_RESET;
            thr_sq_reg         <= THR_SQ_RESET;
        end else begin
            thr_sq_reg <= THR_SQ_W'(flat_threshold_reg) * THR_SQ_W'(flat_threshold_reg);
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_FLAT_THRESHOLD: flat_threshold_reg <= cfg_wr_data[THR_W-1:0];
                    REG_SPREAD_COUNT:   spread_count_reg   <= cfg_wr_data[SPREAD_W-1:0];
                endcase
            end
        end
    end

    // The output register is the only place a stall can come from.
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    tdlr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_tvalid),
        .roll      (s_tdata[ANGLE_W-1:0]),
        .pitch     (s_tdata[2*ANGLE_W-1:ANGLE_W]),
        .valid_out (front_valid),
        .vec_out   (front_vec),
        .zero_out  (front_zero),
        .sq_roll   (sq_roll),
        .sq_pitch  (sq_pitch)
    );

    // Flat when the squared magnitude is below the squared threshold.
    always_comb begin
        mag_sq         = SUM_W'(sq_roll) + SUM_W'(sq_pitch);
        front_tag.flat = mag_sq < SUM_W'(thr_sq_reg);
        front_tag.zero = front_zero;
    end

    tdlr_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (front_valid),
        .vec_in    (front_vec),
        .tag_in    (front_tag),
        .valid_out (rot_valid),
        .vec_out   (rot_vec),
        .tag_out   (rot_tag)
    );

    tdlr_sector_mask u_sector_mask (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .valid_in     (rot_valid),
        .z_in         (rot_vec.z),
        .tag_in       (rot_tag),
        .spread_count (spread_count_reg),
        .valid_out    (out_valid),
        .ring_mask    (ring_mask),
        .center_on    (center_on)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{(M_TDATA_W-MASK_W-1){1'b0}}, center_on, ring_mask};

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("top: input stalled with no word waiting at the output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && center_on) |-> (ring_mask == '0))
        else $error("top: centre LED and ring lit together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !center_on && RING_LEDS <= MASK_W) |-> (ring_mask != '0))
        else $error("top: tilted word lit no ring LED");

endmodule
